@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker of the splitmix range core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SMRG_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("splitmix range core: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SMRG_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("splitmix range core: next-cycle check failed");

`endif

@@ rtl/smrg_pkg.sv @@
// Shared constants, state and command types of the splitmix range core.
// No dependencies; imported by the controller, datapath, top level and checker.
`timescale 1ns / 1ps

package smrg_pkg;

    localparam int SEED_W  = 64;
    localparam int BOUND_W = 32;
    localparam int SPAN_W  = BOUND_W + 1;
    localparam int HALF_W  = SEED_W / 2;

    localparam logic [SEED_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [SEED_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [SEED_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
    localparam int MIX_SHIFT_A = 30;
    localparam int MIX_SHIFT_B = 27;
    localparam int MIX_SHIFT_C = 31;

    localparam int DIV_STEPS = SEED_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 32;

    // Input beat kinds carried on tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ROLL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MIX_A,
        ST_MUL_B,
        ST_MIX_B,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Partial products of a 64-bit product truncated to 64 bits.
    typedef enum logic [1:0] {
        PH_LL,
        PH_LH,
        PH_HL
    } mul_phase_t;

    typedef struct packed {
        logic       load_seed;
        logic       start_roll;
        logic       mul_en;
        mul_phase_t mul_phase;
        logic       mul_use_b;
        logic       mix_a;
        logic       mix_b;
        logic       div_step;
        logic       emit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/splitmix_range_random_generator_core.sv @@
// Top level of the splitmix64 range generator: controller plus datapath.
// Depends on smrg_pkg, smrg_ctrl and smrg_datapath.
`timescale 1ns / 1ps

// A load beat (tuser = 0) replaces the 64-bit seed and gives no result.
// A roll beat (tuser = 1) advances the seed by the golden-ratio step, runs
// the splitmix64 finalizer and reduces the mix modulo the inclusive span of
// the two signed bounds (swapped when given in reverse), then adds the lower
// bound. A roll occupies the block from its accept cycle through two 64-bit
// multiplies, built from the LL, LH and HL partial products on one shared
// 32x32 multiplier and each followed by a mix step, through 64 steps of the
// radix-2 remainder unit, and up to the write of the output register. Input
// ready is low during that time. The result sits in an output register, so
// the next beat is taken while it waits for m_axis_tready; a second roll can
// only finish once that register is free. The seed resets to zero.
module splitmix_range_random_generator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] range_low, [63:32] range_high, [127:64] seed_value
    input  logic [smrg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] cmd
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] roll_value
    output logic [smrg_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import smrg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Split the input beat into its fields.
    logic [BOUND_W-1:0] range_low;
    logic [BOUND_W-1:0] range_high;
    logic [SEED_W-1:0]  seed_value;

    assign range_low  = s_axis_tdata[BOUND_W-1:0];
    assign range_high = s_axis_tdata[2*BOUND_W-1:BOUND_W];
    assign seed_value = s_axis_tdata[2*BOUND_W+SEED_W-1:2*BOUND_W];

    // Sequencer: owns the handshake on the input side and steps the datapath.
    smrg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    // Seed, mixer, remainder unit and the output register.
    smrg_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .range_low  (range_low),
        .range_high (range_high),
        .seed_value (seed_value),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_data   (m_axis_tdata),
        .status     (status)
    );

endmodule

@@ rtl/smrg_ctrl.sv @@
// Sequencer of the splitmix range core: accepts beats and steps the datapath.
// Depends on smrg_pkg.
`timescale 1ns / 1ps

module smrg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_kind,
    input  smrg_pkg::dp_status_t status,
    output logic                in_ready,
    output smrg_pkg::dp_cmd_t   cmd
);
    import smrg_pkg::*;

    state_t               state_reg, state_next;
    mul_phase_t           phase_reg, phase_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 div_last;

    assign div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_LL;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and counters.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                phase_next = PH_LL;
                cnt_next   = '0;
                if (in_valid && in_kind == CMD_ROLL)
                    state_next = ST_MUL_A;
            end
            ST_MUL_A, ST_MUL_B:
            begin
                case (phase_reg)
                    PH_LL:   phase_next = PH_LH;
                    PH_LH:   phase_next = PH_HL;
                    default:
                    begin
                        phase_next = PH_LL;
                        state_next = (state_reg == ST_MUL_A) ? ST_MIX_A : ST_MIX_B;
                    end
                endcase
            end
            ST_MIX_A: state_next = ST_MUL_B;
            ST_MIX_B: state_next = ST_DIV;
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        cmd       = '0;
        cmd.mul_phase = phase_reg;
        in_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.load_seed  = in_valid && (in_kind == CMD_LOAD);
                cmd.start_roll = in_valid && (in_kind == CMD_ROLL);
            end
            ST_MUL_A:  cmd.mul_en = 1'b1;
            ST_MUL_B:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_use_b = 1'b1;
            end
            ST_MIX_A:  cmd.mix_a    = 1'b1;
            ST_MIX_B:  cmd.mix_b    = 1'b1;
            ST_DIV:    cmd.div_step = 1'b1;
            ST_EMIT:   cmd.emit     = status.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

@@ rtl/smrg_datapath.sv @@
// Datapath of the splitmix range core: seed, mixer with a shared 32x32
// multiplier, radix-2 remainder unit and output register. Depends on smrg_pkg.
`timescale 1ns / 1ps

module smrg_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  smrg_pkg::dp_cmd_t            cmd,
    input  logic [smrg_pkg::BOUND_W-1:0] range_low,
    input  logic [smrg_pkg::BOUND_W-1:0] range_high,
    input  logic [smrg_pkg::SEED_W-1:0]  seed_value,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [smrg_pkg::BOUND_W-1:0] out_data,
    output smrg_pkg::dp_status_t         status
);
    import smrg_pkg::*;

    logic [SEED_W-1:0]  seed_reg, seed_next;
    logic [SEED_W-1:0]  z_reg, z_next;
    logic [SEED_W-1:0]  acc_reg, acc_next;
    logic [BOUND_W-1:0] lo_reg, lo_next;
    logic [SPAN_W-1:0]  span_reg, span_next;
    logic [SPAN_W-1:0]  rem_reg, rem_next;
    logic [BOUND_W-1:0] out_data_reg, out_data_next;
    logic               out_valid_reg, out_valid_next;

    logic [SEED_W-1:0]  seed_adv;
    logic [SEED_W-1:0]  mul_k;
    logic [HALF_W-1:0]  mul_a, mul_b;
    logic [SEED_W-1:0]  prod;
    logic               swap;
    logic [BOUND_W-1:0] lo_sel, hi_sel;
    logic [SPAN_W-1:0]  diff;
    logic [SPAN_W:0]    rem_shift, rem_sub;

    assign seed_adv = seed_reg + GOLDEN_STEP;
    assign swap     = $signed(range_low) > $signed(range_high);
    assign lo_sel   = swap ? range_high : range_low;
    assign hi_sel   = swap ? range_low : range_high;
    assign diff     = {hi_sel[BOUND_W-1], hi_sel} - {lo_sel[BOUND_W-1], lo_sel};

    assign mul_k = cmd.mul_use_b ? MIX_MUL_B : MIX_MUL_A;

    always_comb
    begin
        case (cmd.mul_phase)
            PH_LH:
            begin
                mul_a = z_reg[HALF_W-1:0];
                mul_b = mul_k[SEED_W-1:HALF_W];
            end
            PH_HL:
            begin
                mul_a = z_reg[SEED_W-1:HALF_W];
                mul_b = mul_k[HALF_W-1:0];
            end
            default:
            begin
                mul_a = z_reg[HALF_W-1:0];
                mul_b = mul_k[HALF_W-1:0];
            end
        endcase
    end

    assign prod = SEED_W'(mul_a) * SEED_W'(mul_b);

    assign rem_shift = {rem_reg, z_reg[SEED_W-1]};
    assign rem_sub   = rem_shift - {1'b0, span_reg};

    always_comb
    begin
        seed_next      = seed_reg;
        z_next         = z_reg;
        acc_next       = acc_reg;
        lo_next        = lo_reg;
        span_next      = span_reg;
        rem_next       = rem_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.load_seed)
            seed_next = seed_value;
        if (cmd.start_roll)
        begin
            seed_next = seed_adv;
            z_next    = seed_adv ^ (seed_adv >> MIX_SHIFT_A);
            lo_next   = lo_sel;
            span_next = diff + SPAN_W'(1);
        end
        if (cmd.mul_en)
        begin
            if (cmd.mul_phase == PH_LL)
                acc_next = prod;
            else
                acc_next = acc_reg + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
        end
        if (cmd.mix_a)
            z_next = acc_reg ^ (acc_reg >> MIX_SHIFT_B);
        if (cmd.mix_b)
        begin
            z_next   = acc_reg ^ (acc_reg >> MIX_SHIFT_C);
            rem_next = '0;
        end
        if (cmd.div_step)
        begin
            z_next   = {z_reg[SEED_W-2:0], 1'b0};
            rem_next = rem_sub[SPAN_W] ? rem_shift[SPAN_W-1:0] : rem_sub[SPAN_W-1:0];
        end
        if (cmd.emit)
        begin
            out_data_next  = lo_reg + rem_reg[BOUND_W-1:0];
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg        <= z_next;
        acc_reg      <= acc_next;
        lo_reg       <= lo_next;
        span_reg     <= span_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

@@ rtl/smrg_checker.sv @@
// Port-level checks of the splitmix range core, bound to the top level.
// Depends on smrg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smrg_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [smrg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import smrg_pkg::*;

    logic in_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    // A load finishes in its accept cycle; the block is ready again next cycle.
    `SMRG_ASSERT_NEXT(a_load_one_cycle, clk, rst_n, in_beat && s_axis_tuser == CMD_LOAD, s_axis_tready)
    // A roll holds off further input while it is computed.
    `SMRG_ASSERT_NEXT(a_roll_busy, clk, rst_n, in_beat && s_axis_tuser == CMD_ROLL, !s_axis_tready)
    // A roll never yields a new result in the cycle right after its accept.
    `SMRG_ASSERT_NEXT(a_roll_no_early, clk, rst_n, in_beat && s_axis_tuser == CMD_ROLL && !m_axis_tvalid, !m_axis_tvalid)
    // A stalled result stays valid and keeps its value.
    `SMRG_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind splitmix_range_random_generator_core smrg_checker u_smrg_checker (.*);

@@ test/splitmix_range_roll_checker.sv @@
// Scoreboard for the splitmix range core: watches both streams, predicts each roll.
// Depends on smrg_pkg for the beat kinds and the stream widths.
`timescale 1ns / 1ps

module splitmix_range_roll_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_valid,
    input  logic                            s_ready,
    // [31:0] range_low, [63:32] range_high, [127:64] seed_value
    input  logic [smrg_pkg::IN_DATA_W-1:0]  s_data,
    // [0] cmd
    input  logic                            s_user,
    input  logic                            m_valid,
    input  logic                            m_ready,
    // [31:0] roll_value
    input  logic [smrg_pkg::OUT_DATA_W-1:0] m_data,
    output int                              fail_count,
    output int                              pending
);

    localparam logic [63:0] SEED_INCREMENT = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] FIRST_MULT     = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] SECOND_MULT    = 64'h94D0_49BB_1331_11EB;

    logic [63:0] seed_copy;
    logic [31:0] expected_rolls[$];

    // splitmix64 finalizer, products truncated to 64 bits
    function automatic logic [63:0] mix64(input logic [63:0] z);
        logic [63:0] t;
        t = (z ^ (z >> 30)) * FIRST_MULT;
        t = (t ^ (t >> 27)) * SECOND_MULT;
        return t ^ (t >> 31);
    endfunction

    function automatic logic [31:0] scale_to_range(input logic [63:0] mixed,
                                                   input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic signed [63:0] swap;
        logic [63:0] span;
        logic [63:0] sum;
        lo = a;
        hi = b;
        if (lo > hi)
        begin
            swap = lo;
            lo   = hi;
            hi   = swap;
        end
        span = hi - lo + 64'sd1;
        sum  = lo + (mixed % span);
        return sum[31:0];
    endfunction

    task automatic report_failure(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            seed_copy = 64'd0;
            expected_rolls.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (m_valid && m_ready)
            begin
                if (expected_rolls.size() == 0)
                    report_failure($sformatf("result beat %0d with no roll pending",
                                             $signed(m_data)));
                else
                begin
                    want = expected_rolls.pop_front();
                    if (m_data !== want)
                        report_failure($sformatf("roll_value got %0d, want %0d",
                                                 $signed(m_data), $signed(want)));
                end
            end
            if (s_valid && s_ready)
            begin
                if (s_user == smrg_pkg::CMD_LOAD)
                    seed_copy = s_data[127:64];
                else
                begin
                    seed_copy = seed_copy + SEED_INCREMENT;
                    expected_rolls = {expected_rolls,
                                      scale_to_range(mix64(seed_copy),
                                                     s_data[31:0], s_data[63:32])};
                end
            end
            pending = expected_rolls.size();
        end
    end

endmodule

@@ test/splitmix_range_random_generator_core_test.sv @@
// Stimulus and verdict for the splitmix range core; the checker does all comparing.
// Depends on smrg_pkg, splitmix_range_random_generator_core and splitmix_range_roll_checker.
`timescale 1ns / 1ps

module splitmix_range_random_generator_core_test;

    localparam logic [31:0] INT_MIN      = 32'h8000_0000;
    localparam logic [31:0] INT_MAX      = 32'h7FFF_FFFF;
    localparam int          RANDOM_BEATS = 950;
    localparam int          CALM_BEATS   = 150;
    localparam int          HOLD_AT_BEAT = 400;
    localparam int          HOLD_CYCLES  = 1500;
    localparam int          DRAIN_CYCLES = 100;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [smrg_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tuser = smrg_pkg::CMD_LOAD;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [smrg_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    int   fail_count;
    int   pending;

    // Stimulus-owned controls read by the receiver process.
    logic calm = 1'b0;          // no idling on either side while high
    logic hold_request = 1'b0;  // ask the receiver for one long hold-off

    // Receiver-owned bookkeeping of that hold-off.
    int   hold_left = 0;
    logic hold_served = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    splitmix_range_random_generator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    splitmix_range_roll_checker u_roll_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_data     (s_axis_tdata),
        .s_user     (s_axis_tuser),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: random back-pressure, a calm stretch, and one long hold-off so
    // the output register stays full, the next roll stalls and the input
    // ready drops while the sender keeps offering beats.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_request && !hold_served)
        begin
            hold_served = 1'b1;
            hold_left   = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (calm)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 17);
    end

    // Offer one beat, maybe after an idle gap, and hold it until accepted.
    // Gaps are mostly short; some are long enough to land anywhere in a roll.
    task automatic send_beat(input logic cmd, input logic [31:0] lo,
                             input logic [31:0] hi, input logic [63:0] seed);
        int gap;
        if (!calm && $urandom_range(99) < 17)
        begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {seed, hi, lo};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Roll beats carry a random, ignored seed field.
    task automatic roll(input logic [31:0] lo, input logic [31:0] hi);
        send_beat(smrg_pkg::CMD_ROLL, lo, hi, {$urandom, $urandom});
    endtask

    // Load beats carry random, ignored bound fields.
    task automatic load(input logic [63:0] seed);
        send_beat(smrg_pkg::CMD_LOAD, $urandom, $urandom, seed);
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(4))
            0:       return INT_MIN;
            1:       return INT_MAX;
            2:       return 32'd0;
            3:       return 32'hFFFF_FFFF;
            default: return 32'd1;
        endcase
    endfunction

    initial
    begin
        logic [31:0] lo;
        logic [31:0] hi;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: rolls from the reset seed, equal, reversed and full spans.
        roll(32'd0, 32'd0);
        roll(INT_MIN, INT_MAX);
        roll(INT_MAX, INT_MIN);
        roll(INT_MAX, INT_MAX);
        roll(INT_MIN, INT_MIN);
        roll(32'd5, -32'sd5);
        roll(32'hFFFF_FFFF, 32'd0);
        roll(32'd1, 32'd6);
        // Loads at the seed extremes, back-to-back loads, and a seed that
        // wraps to zero on the next step.
        load(64'd0);
        roll(INT_MIN, INT_MAX);
        load(64'hFFFF_FFFF_FFFF_FFFF);
        roll(INT_MIN, INT_MAX);
        roll(-32'sd100, 32'd100);
        load(64'h8000_0000_0000_0000);
        roll(32'd0, 32'd1);
        load({$urandom, $urandom});
        load(64'h61C8_8646_80B5_83EB);
        roll(INT_MIN, INT_MAX);
        roll(32'd0, INT_MAX);
        roll(INT_MIN, 32'hFFFF_FFFF);

        // Random: mostly rolls with a mix of bound shapes, some loads.
        calm <= 1'b1;
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i == CALM_BEATS)
                calm <= 1'b0;
            if (i == HOLD_AT_BEAT)
                hold_request <= 1'b1;
            if ($urandom_range(99) < 15)
                load({$urandom, $urandom});
            else
            begin
                case ($urandom_range(4))
                    0:
                    begin
                        lo = $urandom;
                        hi = $urandom;
                    end
                    1:
                    begin
                        lo = $urandom;
                        hi = lo + $urandom_range(0, 15);
                    end
                    2:
                    begin
                        lo = pick_extreme();
                        hi = pick_extreme();
                    end
                    3:
                    begin
                        lo = $urandom;
                        hi = lo;
                    end
                    default:
                    begin
                        lo = 32'd0;
                        hi = $urandom_range(1, 1000);
                    end
                endcase
                // Swap half the time so reversed bounds show up in every shape.
                if ($urandom_range(1))
                    roll(hi, lo);
                else
                    roll(lo, hi);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then give late or extra results a chance to show up.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: roughly ten times the slowest expected run.
    initial
    begin
        #8000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
